[design/eth_ipv4_tcp_header_parser_core_assert.svh]
// assertion macros for the ethernet / ipv4 / tcp header parser
// expects clk_i and rst_ni in the scope of each use
`ifndef ETH_IPV4_TCP_HEADER_PARSER_CORE_ASSERT_SVH
`define ETH_IPV4_TCP_HEADER_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define EIP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define EIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[design/eip_pkg.sv]
// shared types and constants for the ethernet / ipv4 / tcp header parser
// no dependencies
package eip_pkg;

  localparam int unsigned MAX_FRAME_BYTES   = 1518;
  localparam int unsigned LINK_HEADER_BYTES = 14;
  localparam int unsigned POS_W             = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [7:0] PROTO_IP   = 8'd0;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [3:0] MIN_HDR_CODE = 4'd5;

  typedef enum logic [2:0] {
    VERDICT_TCP_OK  = 3'd0,
    VERDICT_BAD_IP  = 3'd1,
    VERDICT_UDP     = 3'd2,
    VERDICT_ICMP    = 3'd3,
    VERDICT_IP      = 3'd4,
    VERDICT_UNKNOWN = 3'd5,
    VERDICT_BAD_TCP = 3'd6,
    VERDICT_PENDING = 3'd7
  } verdict_e;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [3:0]       ip_code;
    logic [7:0]       proto;
    logic [15:0]      total_len;
    logic [31:0]      src_addr;
    logic [31:0]      dst_addr;
    logic [31:0]      ports;
    logic [3:0]       tcp_code;
    verdict_e         verdict;
  } eip_frame_t;

  localparam eip_frame_t FRAME_RESET = '{
    pos:       '0,
    ip_code:   '0,
    proto:     '0,
    total_len: '0,
    src_addr:  '0,
    dst_addr:  '0,
    ports:     '0,
    tcp_code:  '0,
    verdict:   VERDICT_PENDING
  };

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] frame_number;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [5:0]  ip_header_bytes;
    logic [5:0]  tcp_header_bytes;
    logic [7:0]  payload_offset;
    logic [15:0] payload_length;
  } eip_summary_t;

endpackage

[design/eip_if.sv]
// valid/ready channels: frame bytes in, frame summaries out
// depends on nothing but the widths of the summary fields
interface eip_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface eip_summary_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] frame_number;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [5:0]  ip_header_bytes;
  logic [5:0]  tcp_header_bytes;
  logic [7:0]  payload_offset;
  logic [15:0] payload_length;

  modport source (
    output valid, output status, output frame_number, output source_address,
    output destination_address, output source_port, output destination_port,
    output ip_header_bytes, output tcp_header_bytes, output payload_offset,
    output payload_length, input ready
  );
  modport sink (
    input valid, input status, input frame_number, input source_address,
    input destination_address, input source_port, input destination_port,
    input ip_header_bytes, input tcp_header_bytes, input payload_offset,
    input payload_length, output ready
  );
endinterface

[design/eip_capture.sv]
// per-byte field capture: next frame state from the current state and one word
// depends on eip_pkg
module eip_capture (
  input  logic [7:0]          data_byte_i,
  input  eip_pkg::eip_frame_t state_i,
  output eip_pkg::eip_frame_t state_o
);
  import eip_pkg::*;

  function automatic verdict_e classify(input logic [7:0] proto);
    verdict_e v;
    unique case (proto)
      PROTO_UDP:  v = VERDICT_UDP;
      PROTO_ICMP: v = VERDICT_ICMP;
      PROTO_IP:   v = VERDICT_IP;
      default:    v = VERDICT_UNKNOWN;
    endcase
    return v;
  endfunction

  logic             in_snap;
  logic             active;
  logic [POS_W-1:0] p;
  logic [POS_W:0]   p_next;
  logic [5:0]       ip_bytes;
  logic [5:0]       tcp_bytes;
  logic [POS_W-1:0] t;
  logic [POS_W:0]   t_next;

  assign in_snap   = state_i.pos < POS_W'(MAX_FRAME_BYTES);
  assign active    = in_snap && (state_i.verdict == VERDICT_PENDING) &&
                     (state_i.pos >= POS_W'(LINK_HEADER_BYTES));
  assign p         = state_i.pos - POS_W'(LINK_HEADER_BYTES);
  assign p_next    = {1'b0, p} + 1'b1;
  assign ip_bytes  = {state_i.ip_code, 2'b00};
  assign tcp_bytes = {state_i.tcp_code, 2'b00};
  assign t         = p - POS_W'(ip_bytes);
  assign t_next    = {1'b0, t} + 1'b1;

  always_comb begin
    state_o = state_i;
    if (in_snap) begin
      state_o.pos = state_i.pos + 1'b1;
    end
    if (active) begin
      if (p == '0) begin
        state_o.ip_code = data_byte_i[3:0];
        if (data_byte_i[3:0] < MIN_HDR_CODE) begin
          state_o.verdict = VERDICT_BAD_IP;
        end
      end else begin
        priority if (p == POS_W'(2) || p == POS_W'(3)) begin
          state_o.total_len = {state_i.total_len[7:0], data_byte_i};
        end else if (p == POS_W'(9)) begin
          state_o.proto = data_byte_i;
        end else if (p >= POS_W'(12) && p <= POS_W'(15)) begin
          state_o.src_addr = {state_i.src_addr[23:0], data_byte_i};
        end else if (p >= POS_W'(16) && p <= POS_W'(19)) begin
          state_o.dst_addr = {state_i.dst_addr[23:0], data_byte_i};
        end else begin
        end

        // last ip header byte settles anything that is not tcp
        if (p_next == (POS_W+1)'(ip_bytes)) begin
          if (state_o.proto != PROTO_TCP) begin
            state_o.verdict = classify(state_o.proto);
          end
        end else if (p >= POS_W'(ip_bytes) && state_o.proto == PROTO_TCP) begin
          priority if (t <= POS_W'(3)) begin
            state_o.ports = {state_i.ports[23:0], data_byte_i};
          end else if (t == POS_W'(12)) begin
            state_o.tcp_code = data_byte_i[7:4];
            if (data_byte_i[7:4] < MIN_HDR_CODE) begin
              state_o.verdict = VERDICT_BAD_TCP;
            end
          end else if (t > POS_W'(12)) begin
            if (t_next == (POS_W+1)'(tcp_bytes)) begin
              state_o.verdict = VERDICT_TCP_OK;
            end
          end else begin
          end
        end
      end
    end
  end

endmodule

[design/eth_ipv4_tcp_header_parser_core.sv]
// ethernet / ipv4 / tcp header parser, one frame word accepted per cycle
// latency: the summary is valid the cycle after the last word is accepted
// throughput: one word per cycle, set by the single capture stage; while a
// summary is held and not taken, every input word stalls until it is taken
// reset: async active low, frame state and frame count cleared at once
module eth_ipv4_tcp_header_parser_core (
  input  logic clk_i,
  input  logic rst_ni,
  eip_byte_if.sink      byte_i,
  eip_summary_if.source summary_o
);
  import eip_pkg::*;

  eip_frame_t   frame_q;
  eip_frame_t   frame_nxt;
  eip_frame_t   frame_d;
  logic [31:0]  count_q;
  logic [31:0]  count_d;
  logic         out_valid_q;
  logic         out_valid_d;
  eip_summary_t summary_q;
  eip_summary_t summary_d;

  logic         in_accept;
  logic [5:0]   ipb;
  logic [5:0]   tcpb;
  logic [6:0]   hdr;
  logic         addr_ok;
  logic         tcp_ok;

  assign byte_i.ready = !out_valid_q || summary_o.ready;
  assign in_accept    = byte_i.valid && byte_i.ready;

  eip_capture u_capture (
    .data_byte_i (byte_i.data_byte),
    .state_i     (frame_q),
    .state_o     (frame_nxt)
  );

  assign ipb     = {frame_nxt.ip_code, 2'b00};
  assign tcpb    = {frame_nxt.tcp_code, 2'b00};
  assign hdr     = {1'b0, ipb} + {1'b0, tcpb};
  assign addr_ok = !(frame_nxt.verdict == VERDICT_BAD_IP ||
                     frame_nxt.verdict == VERDICT_PENDING);
  assign tcp_ok  = frame_nxt.verdict == VERDICT_TCP_OK;

  always_comb begin
    summary_d                     = summary_q;
    summary_d.status              = frame_nxt.verdict;
    summary_d.frame_number        = count_q + 32'd1;
    summary_d.source_address      = addr_ok ? frame_nxt.src_addr : '0;
    summary_d.destination_address = addr_ok ? frame_nxt.dst_addr : '0;
    summary_d.ip_header_bytes     = ipb;
    summary_d.tcp_header_bytes    =
      (tcp_ok || frame_nxt.verdict == VERDICT_BAD_TCP) ? tcpb : '0;
    summary_d.source_port         = tcp_ok ? frame_nxt.ports[31:16] : '0;
    summary_d.destination_port    = tcp_ok ? frame_nxt.ports[15:0] : '0;
    summary_d.payload_offset      = tcp_ok ? (8'(LINK_HEADER_BYTES) + {1'b0, hdr}) : '0;
    if (tcp_ok && frame_nxt.total_len > {9'd0, hdr}) begin
      summary_d.payload_length = frame_nxt.total_len - {9'd0, hdr};
    end else begin
      summary_d.payload_length = '0;
    end
  end

  always_comb begin
    frame_d     = frame_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !summary_o.ready;
    if (in_accept) begin
      if (byte_i.last_byte) begin
        frame_d     = FRAME_RESET;
        count_d     = count_q + 32'd1;
        out_valid_d = 1'b1;
      end else begin
        frame_d = frame_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= FRAME_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      frame_q     <= frame_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // summary payload loads only with a closing word
  always_ff @(posedge clk_i) begin
    if (in_accept && byte_i.last_byte) begin
      summary_q <= summary_d;
    end
  end

  assign summary_o.valid               = out_valid_q;
  assign summary_o.status              = summary_q.status;
  assign summary_o.frame_number        = summary_q.frame_number;
  assign summary_o.source_address      = summary_q.source_address;
  assign summary_o.destination_address = summary_q.destination_address;
  assign summary_o.source_port         = summary_q.source_port;
  assign summary_o.destination_port    = summary_q.destination_port;
  assign summary_o.ip_header_bytes     = summary_q.ip_header_bytes;
  assign summary_o.tcp_header_bytes    = summary_q.tcp_header_bytes;
  assign summary_o.payload_offset      = summary_q.payload_offset;
  assign summary_o.payload_length      = summary_q.payload_length;

endmodule

[design/eip_checker.sv]
// port-level checks for the header parser, attached by bind
// depends on eth_ipv4_tcp_header_parser_core_assert.svh
`include "eth_ipv4_tcp_header_parser_core_assert.svh"

module eip_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_status_i,
  input logic [31:0] out_frame_i
);

  logic out_take;
  assign out_take = out_valid_i && out_ready_i;

  // a waiting summary holds
  `EIP_ASSERT_NEXT(a_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_status_i) && $stable(out_frame_i))

  // a closing word always yields a summary next cycle
  `EIP_ASSERT_NEXT(a_close, in_valid_i && in_ready_i && in_last_i, out_valid_i)

  // input never stalls with the summary register empty
  `EIP_ASSERT_NOW(a_ready, !out_valid_i, in_ready_i)

  // back-to-back summaries carry consecutive frame numbers
  `EIP_ASSERT_NOW(a_count, $past(out_take) && out_valid_i,
    out_frame_i == $past(out_frame_i) + 32'd1)

endmodule

bind eth_ipv4_tcp_header_parser_core eip_checker u_eip_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (byte_i.valid),
  .in_ready_i   (byte_i.ready),
  .in_last_i    (byte_i.last_byte),
  .out_valid_i  (summary_o.valid),
  .out_ready_i  (summary_o.ready),
  .out_status_i (summary_o.status),
  .out_frame_i  (summary_o.frame_number)
);
